>>> hw/rtl/dca_pkg.sv
// ----------------------------------------------------------------------------
// dca_pkg
// Shared types and constants of the depthwise convolution block.
// ----------------------------------------------------------------------------
package dca_pkg;

    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_CHANNELS = 32;
    localparam int MAX_KERNEL   = 7;

    localparam int IMG_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int TAP_W     = $clog2(MAX_KERNEL * MAX_KERNEL);

    localparam int ACC_W = 40;
    localparam int T_W   = 56;
    localparam int POS_W = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] FUNC_WEIGHT  = 3'd0;
    localparam logic [2:0] FUNC_BIAS    = 3'd1;
    localparam logic [2:0] FUNC_SLOPE   = 3'd2;
    localparam logic [2:0] FUNC_SAMPLE  = 3'd3;
    localparam logic [2:0] FUNC_COMPUTE = 3'd4;

    localparam logic [2:0] ACT_RELU  = 3'd1;
    localparam logic [2:0] ACT_LEAKY = 3'd2;
    localparam logic [2:0] ACT_CLAMP = 3'd3;
    localparam logic [2:0] ACT_PRELU = 3'd4;

    localparam logic [2:0] REG_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_KERNEL  = 3'd2;
    localparam logic [2:0] REG_STRIDE  = 3'd3;
    localparam logic [2:0] REG_PADDING = 3'd4;
    localparam logic [2:0] REG_MODE    = 3'd5;
    localparam logic [2:0] REG_LOW     = 3'd6;
    localparam logic [2:0] REG_HIGH    = 3'd7;

    typedef enum logic [2:0] {
        K_WEIGHT,
        K_BIAS,
        K_SLOPE,
        K_SAMPLE,
        K_COMPUTE
    } kind_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [4:0]         channel;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [4:0]         channel;
        logic signed [15:0] value;
    } op_t;

endpackage

>>> hw/rtl/dca_ram.sv
// ----------------------------------------------------------------------------
// dca_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/dca_front.sv
// ----------------------------------------------------------------------------
// dca_front
// Input side: takes items, drops dead ones, and queues the rest.
// ----------------------------------------------------------------------------
module dca_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dca_pkg::in_item_t in_data,
    output logic              op_valid,
    input  logic              op_pop,
    output dca_pkg::op_t      op
);

    dca_pkg::op_t                  queue_reg [dca_pkg::QUEUE_DEPTH];
    logic [dca_pkg::QUEUE_AW-1:0]  head_reg, head_next;
    logic [dca_pkg::QUEUE_AW-1:0]  tail_reg, tail_next;
    logic [dca_pkg::QUEUE_AW:0]    count_reg, count_next;
    dca_pkg::op_t                  cls;
    logic                          keep;
    logic                          push;

    always_comb
    begin
        cls.row     = in_data.row;
        cls.col     = in_data.col;
        cls.channel = in_data.channel;
        cls.value   = in_data.value;
        cls.kind    = dca_pkg::K_COMPUTE;
        keep        = 1'b0;
        unique case (in_data.func)
            dca_pkg::FUNC_WEIGHT:
            begin
                cls.kind = dca_pkg::K_WEIGHT;
                keep = (32'(in_data.row) < dca_pkg::MAX_KERNEL)
                    && (32'(in_data.col) < dca_pkg::MAX_KERNEL)
                    && (32'(in_data.channel) < dca_pkg::MAX_CHANNELS);
            end
            dca_pkg::FUNC_BIAS:
            begin
                cls.kind = dca_pkg::K_BIAS;
                keep = 32'(in_data.channel) < dca_pkg::MAX_CHANNELS;
            end
            dca_pkg::FUNC_SLOPE:
            begin
                cls.kind = dca_pkg::K_SLOPE;
                keep = 32'(in_data.channel) < dca_pkg::MAX_CHANNELS;
            end
            dca_pkg::FUNC_SAMPLE:
            begin
                cls.kind = dca_pkg::K_SAMPLE;
                keep = (32'(in_data.row) < dca_pkg::MAX_HEIGHT)
                    && (32'(in_data.col) < dca_pkg::MAX_WIDTH)
                    && (32'(in_data.channel) < dca_pkg::MAX_CHANNELS);
            end
            dca_pkg::FUNC_COMPUTE:
            begin
                cls.kind = dca_pkg::K_COMPUTE;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = 32'(count_reg) < dca_pkg::QUEUE_DEPTH;
    assign push     = in_valid && in_ready && keep;
    assign op_valid = count_reg != '0;
    assign op       = queue_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (op_pop && op_valid)
        begin
            head_next = head_reg + 1'b1;
        end
        if (push && !(op_pop && op_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && op_pop && op_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[tail_reg] <= cls;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= dca_pkg::QUEUE_DEPTH)
        else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !push) |=> (count_reg == '0))
        else $error("queue count moved without a transfer");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg - head_reg) == count_reg[dca_pkg::QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> hw/rtl/dca_back.sv
// ----------------------------------------------------------------------------
// dca_back
// Execution side: store writes, tap walk with one MAC per cycle,
// activation, rounding and the output register.
// ----------------------------------------------------------------------------
module dca_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               op_valid,
    output logic               op_pop,
    input  dca_pkg::op_t       op,
    output logic               out_valid,
    input  logic               out_ready,
    output dca_pkg::out_item_t out_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TAP   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_ACT   = 6'b001000,
        S_RND   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]         height_reg, width_reg;
    logic [2:0]         kernel_reg, stride_reg, padding_reg, mode_reg;
    logic signed [15:0] low_reg, high_reg;

    logic signed [15:0] bias_reg  [dca_pkg::MAX_CHANNELS];
    logic signed [15:0] slope_reg [dca_pkg::MAX_CHANNELS];

    logic [4:0]                      ch_reg;
    logic signed [dca_pkg::POS_W-1:0] oy_reg, ox_reg;
    logic [2:0]                      ky_reg, kx_reg;
    logic [2:0]                      k_eff;
    logic [6:0]                      h_eff, w_eff;
    logic signed [dca_pkg::POS_W-1:0] sy, sx;
    logic                            tap_ok, last_tap;

    logic                            s1_vld_reg, s2_vld_reg;
    logic signed [31:0]              prod_reg;
    logic signed [dca_pkg::ACC_W-1:0] acc_reg;
    logic signed [dca_pkg::T_W-1:0]  t_reg;
    logic                            out_valid_reg;
    dca_pkg::out_item_t              out_reg;

    logic                        img_we, wgt_we;
    logic [dca_pkg::IMG_AW-1:0]  img_addr;
    logic [dca_pkg::WGT_AW-1:0]  wgt_addr;
    logic [15:0]                 img_rdata, wgt_rdata;
    logic [dca_pkg::TAP_W-1:0]   tap_idx;

    logic signed [dca_pkg::T_W-1:0] t_calc, t_mul, t_pos, lo_b, hi_b, acc_cl;
    logic signed [15:0]             slope_sel;
    logic signed [dca_pkg::T_W-1:0] t_rnd;
    logic signed [dca_pkg::T_W-29:0] r;
    logic                            out_free;

    dca_ram #(.WIDTH(16), .DEPTH(dca_pkg::IMG_DEPTH)) u_img (
        .clk   (clk),
        .we    (img_we),
        .addr  (img_addr),
        .wdata (op.value),
        .rdata (img_rdata)
    );

    dca_ram #(.WIDTH(16), .DEPTH(dca_pkg::WGT_DEPTH)) u_wgt (
        .clk   (clk),
        .we    (wgt_we),
        .addr  (wgt_addr),
        .wdata (op.value),
        .rdata (wgt_rdata)
    );

    assign k_eff = (32'(kernel_reg) > dca_pkg::MAX_KERNEL) ?
                   3'(dca_pkg::MAX_KERNEL) : kernel_reg;
    assign h_eff = (32'(height_reg) > dca_pkg::MAX_HEIGHT) ?
                   7'(dca_pkg::MAX_HEIGHT) : 7'(height_reg);
    assign w_eff = (32'(width_reg) > dca_pkg::MAX_WIDTH) ?
                   7'(dca_pkg::MAX_WIDTH) : 7'(width_reg);

    assign sy = oy_reg + dca_pkg::POS_W'(ky_reg);
    assign sx = ox_reg + dca_pkg::POS_W'(kx_reg);
    assign tap_ok = (sy >= 0) && (sy < dca_pkg::POS_W'(h_eff))
                 && (sx >= 0) && (sx < dca_pkg::POS_W'(w_eff));
    assign last_tap = (ky_reg == k_eff - 3'd1) && (kx_reg == k_eff - 3'd1);

    assign op_pop = (state_reg == S_IDLE) && op_valid;
    assign img_we = op_pop && (op.kind == dca_pkg::K_SAMPLE);
    assign wgt_we = op_pop && (op.kind == dca_pkg::K_WEIGHT);

    always_comb
    begin
        if (state_reg == S_TAP)
        begin
            tap_idx  = dca_pkg::TAP_W'(32'(ky_reg) * dca_pkg::MAX_KERNEL + 32'(kx_reg));
            img_addr = dca_pkg::IMG_AW'((32'(sy[dca_pkg::ROW_W-1:0]) * dca_pkg::MAX_WIDTH
                     + 32'(sx[dca_pkg::COL_W-1:0])) * dca_pkg::MAX_CHANNELS + 32'(ch_reg));
        end
        else
        begin
            tap_idx  = dca_pkg::TAP_W'(32'(op.row) * dca_pkg::MAX_KERNEL + 32'(op.col));
            img_addr = dca_pkg::IMG_AW'((32'(op.row[dca_pkg::ROW_W-1:0]) * dca_pkg::MAX_WIDTH
                     + 32'(op.col[dca_pkg::COL_W-1:0])) * dca_pkg::MAX_CHANNELS
                     + 32'(op.channel));
        end
        wgt_addr = dca_pkg::WGT_AW'(32'(tap_idx) * dca_pkg::MAX_CHANNELS
                 + 32'((state_reg == S_TAP) ? ch_reg : op.channel));
    end

    // activation in Q.28
    always_comb
    begin
        slope_sel = (mode_reg == dca_pkg::ACT_LEAKY) ? low_reg : slope_reg[ch_reg];
        t_pos     = dca_pkg::T_W'(acc_reg) <<< 14;
        t_mul     = dca_pkg::T_W'(acc_reg) * dca_pkg::T_W'(slope_sel);
        lo_b      = dca_pkg::T_W'(low_reg) <<< 14;
        hi_b      = dca_pkg::T_W'(high_reg) <<< 14;
        acc_cl    = dca_pkg::T_W'(acc_reg);
        if (acc_cl < lo_b)
        begin
            acc_cl = lo_b;
        end
        if (acc_cl > hi_b)
        begin
            acc_cl = hi_b;
        end
        case (mode_reg)
            dca_pkg::ACT_RELU:  t_calc = (acc_reg < 0) ? '0 : t_pos;
            dca_pkg::ACT_LEAKY,
            dca_pkg::ACT_PRELU: t_calc = (acc_reg < 0) ? t_mul : t_pos;
            dca_pkg::ACT_CLAMP: t_calc = acc_cl <<< 14;
            default:            t_calc = t_pos;
        endcase
    end

    assign t_rnd    = t_reg + (dca_pkg::T_W'(1) <<< 27);
    assign r        = t_rnd[dca_pkg::T_W-1:28];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid && op.kind == dca_pkg::K_COMPUTE)
                begin
                    state_next = (k_eff == 3'd0) ? S_DRAIN : S_TAP;
                end
            end
            S_TAP:   state_next = last_tap ? S_DRAIN : S_TAP;
            S_DRAIN: state_next = (!s1_vld_reg && !s2_vld_reg) ? S_ACT : S_DRAIN;
            S_ACT:   state_next = S_RND;
            S_RND:   state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            height_reg    <= 6'd32;
            width_reg     <= 6'd32;
            kernel_reg    <= 3'd3;
            stride_reg    <= 3'd1;
            padding_reg   <= 3'd1;
            mode_reg      <= 3'd0;
            low_reg       <= 16'sd0;
            high_reg      <= 16'sd32767;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < dca_pkg::MAX_CHANNELS; i++)
            begin
                bias_reg[i]  <= '0;
                slope_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= (state_reg == S_TAP) && tap_ok;
            s2_vld_reg <= s1_vld_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dca_pkg::REG_HEIGHT:  height_reg  <= cfg_data[5:0];
                    dca_pkg::REG_WIDTH:   width_reg   <= cfg_data[5:0];
                    dca_pkg::REG_KERNEL:  kernel_reg  <= cfg_data[2:0];
                    dca_pkg::REG_STRIDE:  stride_reg  <= cfg_data[2:0];
                    dca_pkg::REG_PADDING: padding_reg <= cfg_data[2:0];
                    dca_pkg::REG_MODE:    mode_reg    <= cfg_data[2:0];
                    dca_pkg::REG_LOW:     low_reg     <= cfg_data;
                    dca_pkg::REG_HIGH:    high_reg    <= cfg_data;
                    default:              mode_reg    <= mode_reg;
                endcase
            end
            if (op_pop && op.kind == dca_pkg::K_BIAS)
            begin
                bias_reg[op.channel] <= op.value;
            end
            if (op_pop && op.kind == dca_pkg::K_SLOPE)
            begin
                slope_reg[op.channel] <= op.value;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop && op.kind == dca_pkg::K_COMPUTE)
        begin
            ch_reg  <= op.channel;
            oy_reg  <= dca_pkg::POS_W'(op.row) * dca_pkg::POS_W'(stride_reg)
                     - dca_pkg::POS_W'(padding_reg);
            ox_reg  <= dca_pkg::POS_W'(op.col) * dca_pkg::POS_W'(stride_reg)
                     - dca_pkg::POS_W'(padding_reg);
            ky_reg  <= 3'd0;
            kx_reg  <= 3'd0;
            acc_reg <= dca_pkg::ACC_W'(bias_reg[op.channel]) <<< 14;
        end
        else
        begin
            if (state_reg == S_TAP)
            begin
                if (kx_reg == k_eff - 3'd1)
                begin
                    kx_reg <= 3'd0;
                    ky_reg <= ky_reg + 3'd1;
                end
                else
                begin
                    kx_reg <= kx_reg + 3'd1;
                end
            end
            if (s2_vld_reg)
            begin
                acc_reg <= acc_reg + dca_pkg::ACC_W'(prod_reg);
            end
        end
        prod_reg <= $signed(img_rdata) * $signed(wgt_rdata);
        if (state_reg == S_ACT)
        begin
            t_reg <= t_calc;
        end
        // loaded only once the previous result has gone
        if (state_reg == S_OUT && out_free)
        begin
            if (r > 32767)
            begin
                out_reg.out_value <= 16'sd32767;
                out_reg.saturated <= 1'b1;
            end
            else if (r < -32768)
            begin
                out_reg.out_value <= -16'sd32768;
                out_reg.saturated <= 1'b1;
            end
            else
            begin
                out_reg.out_value <= r[15:0];
                out_reg.saturated <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(img_we || wgt_we))
        else $error("store write during a compute");
    a_act_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("activation started before the MAC pipe drained");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> out_valid_reg)
        else $error("result not presented");

endmodule

>>> hw/rtl/depthwise_convolution_activation.sv
// ----------------------------------------------------------------------------
// depthwise_convolution_activation
// Depthwise 2-D convolution with padding, stride and activation.
// ----------------------------------------------------------------------------
// Items are queued four deep and run one at a time. A store write is done as
// the item is taken from the queue. A compute is taken from the queue, then
// walks the kernel_size squared taps (one image/weight RAM read and one MAC per
// cycle), then drains the pipe and passes through a state each for activation,
// rounding and loading the output register. The last of these waits while an
// earlier result is still unread; further items are taken into the queue
// meanwhile.
module depthwise_convolution_activation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  dca_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dca_pkg::out_item_t out_data
);

    logic         op_valid;
    logic         op_pop;
    dca_pkg::op_t op;

    dca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_pop   (op_pop),
        .op       (op)
    );

    dca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> verif/depthwise_convolution_activation_test.sv
// ----------------------------------------------------------------------------
// depthwise_convolution_activation_test
// Self-checking bench for the depthwise convolution block. It fills kernel
// and image stores, requests output samples under a range of geometry and activation
// settings, and checks every result against a local predictor or a scripted value.
// ----------------------------------------------------------------------------
module depthwise_convolution_activation_test;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_SPARE = 3'd5;
    localparam logic [2:0] FUNC_IDLE5 = 3'd5;
    localparam logic [2:0] FUNC_IDLE7 = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS = 85;

    typedef struct packed {
        logic               chk;
        dca_pkg::in_item_t  item;
        dca_pkg::out_item_t want;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = dca_pkg::REG_HEIGHT;
    logic [15:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    dca_pkg::in_item_t  in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    dca_pkg::out_item_t out_data;

    logic signed [15:0] image_mem [dca_pkg::IMG_DEPTH];
    logic signed [15:0] kernel_mem [dca_pkg::WGT_DEPTH];
    logic signed [15:0] bias_mem [dca_pkg::MAX_CHANNELS];
    logic signed [15:0] slope_mem [dca_pkg::MAX_CHANNELS];
    bit image_set [dca_pkg::IMG_DEPTH];
    bit kernel_set [dca_pkg::WGT_DEPTH];
    logic [15:0] regs [8];

    dca_pkg::out_item_t pending_q [$];
    step_t     script [$];
    int mismatches = 0;
    int outputs_seen = 0;
    int items_sent = 0;
    int stall_count = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #4 clk = ~clk;

    depthwise_convolution_activation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    function automatic dca_pkg::out_item_t conv_sample(int r, int c, int ch);
        longint acc, t, lo, hi, res;
        int hh, ww, k, sy, sx;
        dca_pkg::out_item_t o;
        hh = (regs[dca_pkg::REG_HEIGHT][5:0] > dca_pkg::MAX_HEIGHT) ?
             dca_pkg::MAX_HEIGHT : int'(regs[dca_pkg::REG_HEIGHT][5:0]);
        ww = (regs[dca_pkg::REG_WIDTH][5:0] > dca_pkg::MAX_WIDTH) ?
             dca_pkg::MAX_WIDTH : int'(regs[dca_pkg::REG_WIDTH][5:0]);
        k = int'(regs[dca_pkg::REG_KERNEL][2:0]);
        acc = longint'(bias_mem[ch]) * 16384;
        for (int ky = 0; ky < k; ky++)
        begin
            sy = r * int'(regs[dca_pkg::REG_STRIDE][2:0]) + ky
               - int'(regs[dca_pkg::REG_PADDING][2:0]);
            if (sy < 0 || sy >= hh)
                continue;
            for (int kx = 0; kx < k; kx++)
            begin
                sx = c * int'(regs[dca_pkg::REG_STRIDE][2:0]) + kx
                   - int'(regs[dca_pkg::REG_PADDING][2:0]);
                if (sx < 0 || sx >= ww)
                    continue;
                acc += longint'(image_mem[(sy * dca_pkg::MAX_WIDTH + sx)
                                          * dca_pkg::MAX_CHANNELS + ch])
                     * longint'(kernel_mem[(ky * dca_pkg::MAX_KERNEL + kx)
                                           * dca_pkg::MAX_CHANNELS + ch]);
            end
        end
        t = acc * 16384;
        case (regs[dca_pkg::REG_MODE][2:0])
            dca_pkg::ACT_RELU:  if (t < 0) t = 0;
            dca_pkg::ACT_LEAKY:
                if (acc < 0) t = acc * longint'($signed(regs[dca_pkg::REG_LOW]));
            dca_pkg::ACT_CLAMP:
            begin
                lo = longint'($signed(regs[dca_pkg::REG_LOW])) * 268435456;
                hi = longint'($signed(regs[dca_pkg::REG_HIGH])) * 268435456;
                if (t < lo) t = lo;
                if (t > hi) t = hi;
            end
            dca_pkg::ACT_PRELU: if (acc < 0) t = acc * longint'(slope_mem[ch]);
            default: ;
        endcase
        res = (t + 134217728) >>> 28;
        o.saturated = 1'b0;
        if (res > 32767)
        begin
            res = 32767;
            o.saturated = 1'b1;
        end
        if (res < -32768)
        begin
            res = -32768;
            o.saturated = 1'b1;
        end
        o.out_value = res[15:0];
        return o;
    endfunction

    // one transfer on the input side; store state follows the accepted item
    task automatic push(dca_pkg::in_item_t it, logic chk = 1'b0,
                        dca_pkg::out_item_t want = '0);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        case (it.func)
            dca_pkg::FUNC_WEIGHT:
                if (it.row < dca_pkg::MAX_KERNEL && it.col < dca_pkg::MAX_KERNEL)
                begin
                    kernel_mem[(it.row * dca_pkg::MAX_KERNEL + it.col)
                               * dca_pkg::MAX_CHANNELS + it.channel] = it.value;
                    kernel_set[(it.row * dca_pkg::MAX_KERNEL + it.col)
                               * dca_pkg::MAX_CHANNELS + it.channel] = 1'b1;
                end
            dca_pkg::FUNC_BIAS:  bias_mem[it.channel] = it.value;
            dca_pkg::FUNC_SLOPE: slope_mem[it.channel] = it.value;
            dca_pkg::FUNC_SAMPLE:
                if (it.row < dca_pkg::MAX_HEIGHT && it.col < dca_pkg::MAX_WIDTH)
                begin
                    image_mem[(it.row * dca_pkg::MAX_WIDTH + it.col)
                              * dca_pkg::MAX_CHANNELS + it.channel] = it.value;
                    image_set[(it.row * dca_pkg::MAX_WIDTH + it.col)
                              * dca_pkg::MAX_CHANNELS + it.channel] = 1'b1;
                end
            dca_pkg::FUNC_COMPUTE:
                pending_q.push_back(chk ? want : conv_sample(it.row, it.col, it.channel));
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 1023) - 512);
    endfunction

    function automatic dca_pkg::in_item_t make_item(logic [2:0] f, int r, int c, int ch,
                                                    logic [15:0] v);
        dca_pkg::in_item_t it;
        it.func = f;
        it.row = 6'(r);
        it.col = 6'(c);
        it.channel = 5'(ch);
        it.value = v;
        return it;
    endfunction

    // writes any tap of the window not yet written, then requests the sample
    task automatic feed_compute(int r, int c, int ch);
        int hh, ww, k, sy, sx;
        hh = (regs[dca_pkg::REG_HEIGHT][5:0] > dca_pkg::MAX_HEIGHT) ?
             dca_pkg::MAX_HEIGHT : int'(regs[dca_pkg::REG_HEIGHT][5:0]);
        ww = (regs[dca_pkg::REG_WIDTH][5:0] > dca_pkg::MAX_WIDTH) ?
             dca_pkg::MAX_WIDTH : int'(regs[dca_pkg::REG_WIDTH][5:0]);
        k = int'(regs[dca_pkg::REG_KERNEL][2:0]);
        for (int ky = 0; ky < k; ky++)
            for (int kx = 0; kx < k; kx++)
            begin
                sy = r * int'(regs[dca_pkg::REG_STRIDE][2:0]) + ky
                   - int'(regs[dca_pkg::REG_PADDING][2:0]);
                sx = c * int'(regs[dca_pkg::REG_STRIDE][2:0]) + kx
                   - int'(regs[dca_pkg::REG_PADDING][2:0]);
                if (sy < 0 || sy >= hh || sx < 0 || sx >= ww)
                    continue;
                if (!image_set[(sy * dca_pkg::MAX_WIDTH + sx) * dca_pkg::MAX_CHANNELS + ch])
                    push(make_item(dca_pkg::FUNC_SAMPLE, sy, sx, ch, rand_value()));
                if (!kernel_set[(ky * dca_pkg::MAX_KERNEL + kx) * dca_pkg::MAX_CHANNELS + ch])
                    push(make_item(dca_pkg::FUNC_WEIGHT, ky, kx, ch, rand_value()));
            end
        push(make_item(dca_pkg::FUNC_COMPUTE, r, c, ch, 16'($urandom)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int h, int w, int k, int s, int p, logic [2:0] m,
                              logic [15:0] lo, logic [15:0] hi);
        logic [15:0] vals [8];
        vals = '{16'(h), 16'(w), 16'(k), 16'(s), 16'(p), 16'(m), lo, hi};
        wait_idle();
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            regs[i] = vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        int start, sel, hh, r, c;
        logic [2:0] f;
        start = items_sent;
        hh = (regs[dca_pkg::REG_HEIGHT][5:0] > dca_pkg::MAX_HEIGHT) ?
             dca_pkg::MAX_HEIGHT : int'(regs[dca_pkg::REG_HEIGHT][5:0]);
        while (items_sent - start < PHASE_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                end
                else
                begin
                    r = $urandom_range(0, hh / 2 + 1);
                    c = $urandom_range(0, hh / 2 + 1);
                end
                feed_compute(r, c, $urandom_range(0, 31));
            end
            else if (sel < 75)
                push(make_item($urandom_range(0, 1) ? dca_pkg::FUNC_BIAS : dca_pkg::FUNC_SLOPE,
                               $urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 31), rand_value()));
            else if (sel < 90)
                push(make_item($urandom_range(0, 1) ? dca_pkg::FUNC_SAMPLE
                                                    : dca_pkg::FUNC_WEIGHT,
                               $urandom_range(0, 6), $urandom_range(0, 6),
                               $urandom_range(0, 31), rand_value()));
            else
            begin
                // stray rows and spare codes; a compute here could reach unwritten taps
                f = 3'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 3'd5 : 3'd0);
                if (f == dca_pkg::FUNC_COMPUTE)
                    f = FUNC_IDLE5;
                push(make_item(f, $urandom_range(32, 63), $urandom_range(0, 63),
                               $urandom_range(0, 31), 16'($urandom)));
            end
        end
    endtask

    task automatic add_step(logic chk, logic [2:0] f, int r, int c, int ch, logic [15:0] v,
                            logic [15:0] wv = 16'h0, logic ws = 1'b0);
        step_t s;
        s.chk = chk;
        s.item = make_item(f, r, c, ch, v);
        s.want.out_value = wv;
        s.want.saturated = ws;
        script.push_back(s);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            outputs_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d", out_data.out_value, out_data.saturated);
            end
            else if (pending_q[0] !== out_data)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: value exp %0d got %0d, sat exp %0b got %0b",
                             outputs_seen, pending_q[0].out_value, out_data.out_value,
                             pending_q[0].saturated, out_data.saturated);
                void'(pending_q.pop_front());
            end
            else
                void'(pending_q.pop_front());
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else if (rst_n)
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("depthwise_convolution_activation_test: errors");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (250) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    initial
    begin
        regs = '{16'd32, 16'd32, 16'd3, 16'd1, 16'd1, 16'(ACT_NONE), 16'd0, 16'd32767};
        foreach (bias_mem[i])
        begin
            bias_mem[i] = '0;
            slope_mem[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: bias-only windows, saturation both ways, ignored items
        add_step(1, dca_pkg::FUNC_COMPUTE, 63, 63, 5, 16'h0, 16'h0, 1'b0);
        add_step(0, dca_pkg::FUNC_BIAS, 0, 0, 31, 16'h7fff);
        add_step(1, dca_pkg::FUNC_COMPUTE, 63, 63, 31, 16'hffff, 16'h7fff, 1'b0);
        add_step(0, dca_pkg::FUNC_BIAS, 0, 0, 0, 16'h8000);
        add_step(1, dca_pkg::FUNC_COMPUTE, 40, 0, 0, 16'h0, 16'h8000, 1'b0);
        add_step(0, dca_pkg::FUNC_WEIGHT, 1, 1, 2, 16'h8000);
        add_step(0, dca_pkg::FUNC_WEIGHT, 1, 2, 2, 16'h0);
        add_step(0, dca_pkg::FUNC_WEIGHT, 2, 1, 2, 16'h0);
        add_step(0, dca_pkg::FUNC_WEIGHT, 2, 2, 2, 16'h0);
        add_step(0, dca_pkg::FUNC_SAMPLE, 0, 0, 2, 16'h8000);
        add_step(0, dca_pkg::FUNC_SAMPLE, 0, 1, 2, 16'h0);
        add_step(0, dca_pkg::FUNC_SAMPLE, 1, 0, 2, 16'h0);
        add_step(0, dca_pkg::FUNC_SAMPLE, 1, 1, 2, 16'h0);
        add_step(1, dca_pkg::FUNC_COMPUTE, 0, 0, 2, 16'h0, 16'h7fff, 1'b1);
        add_step(0, dca_pkg::FUNC_WEIGHT, 1, 1, 2, 16'h7fff);
        add_step(1, dca_pkg::FUNC_COMPUTE, 0, 0, 2, 16'h0, 16'h8000, 1'b1);
        add_step(0, dca_pkg::FUNC_WEIGHT, 7, 63, 2, 16'h1234);
        add_step(0, dca_pkg::FUNC_SAMPLE, 40, 0, 2, 16'h5555);
        add_step(0, dca_pkg::FUNC_SAMPLE, 1, 40, 2, 16'haaaa);
        add_step(0, FUNC_IDLE5, 63, 63, 31, 16'hffff);
        add_step(0, FUNC_IDLE7, 0, 0, 0, 16'h0);
        add_step(0, dca_pkg::FUNC_SLOPE, 0, 0, 2, 16'h4000);
        add_step(0, dca_pkg::FUNC_SAMPLE, 0, 1, 2, 16'h0100);
        add_step(0, dca_pkg::FUNC_COMPUTE, 0, 0, 2, 16'h0);
        foreach (script[i])
            push(script[i].item, script[i].chk, script[i].want);

        set_config(6, 6, 3, 1, 1, ACT_NONE, 16'h0, 16'h7fff);
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            feed_compute($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 31));
        random_phase();
        set_config(4, 5, 1, 2, 0, dca_pkg::ACT_RELU, 16'h0, 16'h7fff);
        random_phase();
        calm = 1'b1;
        set_config(8, 8, 7, 1, 3, dca_pkg::ACT_LEAKY, 16'h0ccd, 16'h0);
        random_phase();
        calm = 1'b0;
        set_config(3, 7, 5, 3, 2, dca_pkg::ACT_CLAMP, 16'hfe00, 16'h0180);
        random_phase();
        set_config(5, 5, 3, 4, 6, dca_pkg::ACT_PRELU, 16'h0, 16'h0);
        random_phase();
        set_config(32, 32, 7, 1, 6, dca_pkg::ACT_CLAMP, 16'h0100, 16'hff00);
        random_phase();
        set_config(63, 63, 0, 0, 0, ACT_SPARE, 16'hffff, 16'h8000);
        random_phase();
        set_config(1, 1, 7, 0, 6, dca_pkg::ACT_LEAKY, 16'h8000, 16'h7fff);
        random_phase();
        set_config(0, 0, 3, 1, 1, dca_pkg::ACT_PRELU, 16'h7fff, 16'h7fff);
        random_phase();
        set_config(2, 3, 6, 2, 5, dca_pkg::ACT_CLAMP, 16'h8000, 16'h7fff);
        random_phase();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_idle();
        if (pending_q.size() != 0)
            mismatches++;
        $display("%0d items sent over ten settings, %0d results checked, %0d mismatches",
                 items_sent, outputs_seen, mismatches);
        if (mismatches == 0)
            $display("depthwise_convolution_activation_test: clean");
        else
            $display("depthwise_convolution_activation_test: errors");
        $finish;
    end

endmodule
